// File: rtl/xcfr_pkg.sv
package xcfr_pkg;

    localparam int MaxFrameDefault = 64;

    // register indexes on the configuration port
    localparam logic [2:0] REG_START_BYTE     = 3'd0;
    localparam logic [2:0] REG_END_BYTE       = 3'd1;
    localparam logic [2:0] REG_BROADCAST_BYTE = 3'd2;
    localparam logic [2:0] REG_UNICAST_BYTE   = 3'd3;
    localparam logic [2:0] REG_READ_CODE      = 3'd4;
    localparam logic [2:0] REG_GET_CODE       = 3'd5;
    localparam logic [2:0] REG_TEST_CODE      = 3'd6;
    localparam logic [2:0] REG_DEVICE_ID      = 3'd7;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [6:0] DEC_RADIX  = 7'd10;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CSUM_BAD  = 3'd1,
        ST_BAD_DEST  = 3'd2,
        ST_ADDR_MISS = 3'd3,
        ST_BAD_CMD   = 3'd4,
        ST_TOO_SHORT = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CMD_READ = 2'd0,
        CMD_GET  = 2'd1,
        CMD_TEST = 2'd2
    } command_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] broadcast_byte;
        logic [7:0] unicast_byte;
        logic [7:0] read_code;
        logic [7:0] get_code;
        logic [7:0] test_code;
        logic [4:0] device_id;
    } cfg_t;

    // bytes captured from the frame under collection
    typedef struct packed {
        logic [7:0]  running_xor;
        logic [15:0] last_two_bytes;
        logic [7:0]  dest_byte;
        logic [15:0] addr_digits;
        logic [15:0] cmd_candidates;
    } frame_t;

    typedef struct packed {
        status_t    status;
        command_t   command;
        logic       is_broadcast;
        logic [6:0] frame_address;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } result_t;

    // {valid, value} of one hex character, either case
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

endpackage

// File: rtl/xcfr_frame_eval.sv
module xcfr_frame_eval import xcfr_pkg::*; #(
    parameter int CntW = 7
) (
    input  cfg_t              cfg,
    input  frame_t            frame,
    input  logic [CntW-1:0]   byte_count,
    output result_t           result
);

    logic [7:0] hi, lo, d1, d2, cb, d1v, d2v;
    logic [4:0] hex_hi, hex_lo;
    logic [7:0] csum, rsum;
    logic       is_b, is_u, digits_ok;
    logic [6:0] addr;

    always_comb begin
        hi     = frame.last_two_bytes[15:8];
        lo     = frame.last_two_bytes[7:0];
        hex_hi = hex_nibble(hi);
        hex_lo = hex_nibble(lo);
        csum   = frame.running_xor ^ hi ^ lo;
        rsum   = {hex_hi[3:0], hex_lo[3:0]};
        is_b   = (frame.dest_byte == cfg.broadcast_byte);
        is_u   = (frame.dest_byte == cfg.unicast_byte);
        d1     = frame.addr_digits[7:0];
        d2     = frame.addr_digits[15:8];
        d1v    = d1 - ASCII_ZERO;
        d2v    = d2 - ASCII_ZERO;
        digits_ok = (d1 inside {[8'h30:8'h39]}) && (d2 inside {[8'h30:8'h39]});
        addr   = 7'(d1v[3:0]) * DEC_RADIX + 7'(d2v[3:0]);
        cb     = is_b ? frame.cmd_candidates[7:0] : frame.cmd_candidates[15:8];

        result = '{status: ST_OK, command: CMD_READ, is_broadcast: 1'b0,
                   frame_address: 7'd0, computed_sum: 8'd0, received_sum: 8'd0};

        if (byte_count < CntW'(3)) begin
            result.status = ST_TOO_SHORT;
        end else begin
            result.computed_sum = csum;
            result.received_sum = rsum;
            if (!hex_hi[4] || !hex_lo[4] || csum != rsum) begin
                result.status = ST_CSUM_BAD;
            end else if (byte_count < CntW'(4)) begin
                // no destination byte ahead of the checksum
                result.status = ST_TOO_SHORT;
            end else if (!is_b && !is_u) begin
                result.status = ST_BAD_DEST;
            end else if (byte_count < (is_b ? CntW'(5) : CntW'(7))) begin
                result.status = ST_TOO_SHORT;
            end else begin
                result.is_broadcast = is_b;
                if (!is_b) begin
                    if (!digits_ok) begin
                        result.status = ST_ADDR_MISS;
                    end else begin
                        result.frame_address = addr;
                        if (addr != {2'b00, cfg.device_id}) begin
                            result.status = ST_ADDR_MISS;
                        end
                    end
                end
                if (result.status == ST_OK) begin
                    if (cb == cfg.read_code) begin
                        result.command = CMD_READ;
                    end else if (cb == cfg.get_code) begin
                        result.command = CMD_GET;
                    end else if (cb == cfg.test_code) begin
                        result.command = CMD_TEST;
                    end else begin
                        result.status = ST_BAD_CMD;
                    end
                end
            end
        end
    end

endmodule

// File: rtl/xor_checked_frame_receiver_top.sv
// xor-checked frame receiver
//
// s_ channel: one received serial byte per request (s_rx_byte), valid/ready.
// m_ channel: one result per completed frame (status, command, broadcast
// flag, address, computed and received checksum), valid/ready.
// cfg_ port: plain register writes, index 0..7, taken at once; only to be
// used while no frame result is outstanding.
//
// throughput: one byte per cycle while s_ready is high; the frame tracker
// updates per accepted byte; an end byte loads the frame's result into the
// result or skid register (if m_ stalls); other bytes leave no trace on m_
// the output has a result register plus a skid register, so bytes keep
// flowing while one result waits; s_ready only drops once both hold a result
// and the receiver still stalls, and rises again as soon as one is taken
// reset (aresetn low, synchronous) restores the default framing bytes and
// codes, device id 0, drops any partial frame and empties both result stages
module xor_checked_frame_receiver_top import xcfr_pkg::*; #(
    parameter int MaxFrame = MaxFrameDefault
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration writes
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    // received bytes
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    // frame results
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [1:0] m_command,
    output logic       m_is_broadcast,
    output logic [6:0] m_frame_address,
    output logic [7:0] m_computed_sum,
    output logic [7:0] m_received_sum
);

    localparam int CntW = $clog2(MaxFrame + 1);

    // byte positions inside a frame, start byte is position 0
    localparam logic [CntW-1:0] POS_DEST   = CntW'(1);
    localparam logic [CntW-1:0] POS_ADDR_H = CntW'(2);
    localparam logic [CntW-1:0] POS_ADDR_L = CntW'(3);
    localparam logic [CntW-1:0] POS_CMD_U  = CntW'(4);
    localparam logic [CntW-1:0] CNT_MAX    = CntW'(MaxFrame);

    cfg_t            cfg_reg;
    logic            in_frame_reg;
    logic [CntW-1:0] byte_count_reg;
    frame_t          frame_reg, frame_next;
    result_t         out_reg, skid_reg, eval_result;
    logic            out_valid_reg, skid_valid_reg;

    logic s_fire, end_seen, out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{start_byte: 8'd36, end_byte: 8'd42, broadcast_byte: 8'd66,
                         unicast_byte: 8'd85, read_code: 8'd82, get_code: 8'd71,
                         test_code: 8'd84, device_id: 5'd0};
        end else if (cfg_we) begin
            case (cfg_index)
                REG_START_BYTE:     cfg_reg.start_byte     <= cfg_data;
                REG_END_BYTE:       cfg_reg.end_byte       <= cfg_data;
                REG_BROADCAST_BYTE: cfg_reg.broadcast_byte <= cfg_data;
                REG_UNICAST_BYTE:   cfg_reg.unicast_byte   <= cfg_data;
                REG_READ_CODE:      cfg_reg.read_code      <= cfg_data;
                REG_GET_CODE:       cfg_reg.get_code       <= cfg_data;
                REG_TEST_CODE:      cfg_reg.test_code      <= cfg_data;
                REG_DEVICE_ID:      cfg_reg.device_id      <= cfg_data[4:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign s_fire   = s_valid && s_ready;
    // end byte closes the frame before the overflow test
    assign end_seen = s_fire && in_frame_reg && (s_rx_byte == cfg_reg.end_byte);

    // capture of the early frame bytes and the running checksum
    always_comb begin
        frame_next = frame_reg;
        case (byte_count_reg)
            POS_DEST:   frame_next.dest_byte = s_rx_byte;
            POS_ADDR_H: begin
                frame_next.addr_digits[7:0]    = s_rx_byte;
                frame_next.cmd_candidates[7:0] = s_rx_byte;
            end
            POS_ADDR_L: frame_next.addr_digits[15:8]    = s_rx_byte;
            POS_CMD_U:  frame_next.cmd_candidates[15:8] = s_rx_byte;
            default:    frame_next.dest_byte = frame_reg.dest_byte;
        endcase
        frame_next.running_xor    = frame_reg.running_xor ^ s_rx_byte;
        frame_next.last_two_bytes = {frame_reg.last_two_bytes[7:0], s_rx_byte};
    end

    // frame tracker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            byte_count_reg <= '0;
        end else if (s_fire) begin
            if (!in_frame_reg) begin
                if (s_rx_byte == cfg_reg.start_byte) begin
                    in_frame_reg   <= 1'b1;
                    byte_count_reg <= CntW'(1);
                end
            end else if (s_rx_byte == cfg_reg.end_byte) begin
                in_frame_reg <= 1'b0;
            end else if (byte_count_reg >= CNT_MAX) begin
                // overflow, frame dropped without a result
                in_frame_reg <= 1'b0;
            end else begin
                byte_count_reg <= byte_count_reg + CntW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (!in_frame_reg) begin
                if (s_rx_byte == cfg_reg.start_byte) begin
                    frame_reg <= '{running_xor: s_rx_byte,
                                   last_two_bytes: {8'h00, s_rx_byte},
                                   dest_byte: 8'h00, addr_digits: 16'h0000,
                                   cmd_candidates: 16'h0000};
                end
            end else if (s_rx_byte != cfg_reg.end_byte && byte_count_reg < CNT_MAX) begin
                frame_reg <= frame_next;
            end
        end
    end

    xcfr_frame_eval #(
        .CntW(CntW)
    ) u_eval (
        .cfg        (cfg_reg),
        .frame      (frame_reg),
        .byte_count (byte_count_reg),
        .result     (eval_result)
    );

    // result register with skid stage
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= end_seen;
            end
        end else if (end_seen) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (end_seen) begin
                out_reg <= eval_result;
            end
        end else if (end_seen) begin
            skid_reg <= eval_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_reg.status;
    assign m_command       = out_reg.command;
    assign m_is_broadcast  = out_reg.is_broadcast;
    assign m_frame_address = out_reg.frame_address;
    assign m_computed_sum  = out_reg.computed_sum;
    assign m_received_sum  = out_reg.received_sum;

endmodule

// File: rtl/xcfr_checker.sv
module xcfr_checker import xcfr_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic [2:0] m_status,
    input logic [1:0] m_command,
    input logic       m_is_broadcast,
    input logic [6:0] m_frame_address,
    input logic [7:0] m_computed_sum,
    input logic [7:0] m_received_sum
);

    // no result survives reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    // bytes only back up when a result is waiting
    assert property (@(posedge aclk) disable iff (!aresetn) !s_ready |-> m_valid)
        else $error("request refused with no result pending");

    // a good frame always has matching sums
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> m_computed_sum == m_received_sum)
        else $error("ok status with checksum mismatch");

    // command and address only accompany the cases that carry them
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK || m_is_broadcast) |->
        m_command == CMD_READ || m_status == ST_OK)
        else $error("command reported on a failed frame");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_broadcast |-> m_frame_address == 7'd0)
        else $error("address on a broadcast frame");

endmodule

bind xor_checked_frame_receiver_top xcfr_checker u_xcfr_checker (.*);
